/* sv/dcmm_pkg.sv */
// ----------------------------------------------------------------------------
// dcmm_pkg: shared types and the magnitude helper for the dual-channel moving median
// Sample and magnitude types, and the magnitude function used at chain entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcmm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0]           mag_t;

  // |v| in one extra bit, so the most negative count keeps its magnitude
  function automatic mag_t mag_of(input sample_t v);
    mag_t ext;
    ext = {v[SAMPLE_W-1], v};
    return v[SAMPLE_W-1] ? (~ext + mag_t'(1)) : ext;
  endfunction

endpackage

/* sv/dual_channel_moving_median.sv */
// ----------------------------------------------------------------------------
// dual_channel_moving_median: two-wheel moving median, ordered by magnitude
// An accepted word enters the window; its median then moves into the output register.
// Throughput: one word per cycle unless a stalled result holds the window full.
// Reset (rst, synchronous): both windows clear to zero, pipeline empties.
// The zeros left by reset are real window entries and take part in ranking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_channel_moving_median
  import dcmm_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input  logic    clk,
  input  logic    rst,
  // input words
  input  logic    count_valid,
  output logic    count_stall,
  input  sample_t left_count,
  input  sample_t right_count,
  // result words
  output logic    median_valid,
  input  logic    median_stall,
  output sample_t left_median,
  output sample_t right_median
);

  // --------------------------------------------------------------------------
  // Handshake and pipeline control.
  // Stage 1 is the window itself: after a shift it holds the state whose
  // median is still owed. It may not shift again until that median has moved
  // into the output register, which can happen in the same cycle.
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic out_free;
  logic move;
  logic accept;

  assign out_free    = !median_valid || !median_stall;
  assign move        = s1_valid && out_free;
  assign count_stall = s1_valid && !out_free;
  assign accept      = count_valid && !count_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      median_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        median_valid <= 1'b1;
      end else if (out_free) begin
        median_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Window chains: tap 0 is the oldest, tap WINDOW_LEN-1 takes the new count.
  // Magnitude is computed once at entry and travels with the sample.
  // --------------------------------------------------------------------------
  sample_t left_win   [WINDOW_LEN];
  mag_t    left_mags  [WINDOW_LEN];
  sample_t right_win  [WINDOW_LEN];
  mag_t    right_mags [WINDOW_LEN];

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_tap
    sample_t l_din;
    mag_t    l_din_mag;
    sample_t r_din;
    mag_t    r_din_mag;

    if (i == WINDOW_LEN - 1) begin : g_head
      assign l_din     = left_count;
      assign l_din_mag = mag_of(left_count);
      assign r_din     = right_count;
      assign r_din_mag = mag_of(right_count);
    end else begin : g_body
      assign l_din     = left_win[i+1];
      assign l_din_mag = left_mags[i+1];
      assign r_din     = right_win[i+1];
      assign r_din_mag = right_mags[i+1];
    end

    dcmm_cell u_left_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (accept),
      .din_sample (l_din),
      .din_mag    (l_din_mag),
      .sample     (left_win[i]),
      .mag        (left_mags[i])
    );

    dcmm_cell u_right_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (accept),
      .din_sample (r_din),
      .din_mag    (r_din_mag),
      .sample     (right_win[i]),
      .mag        (right_mags[i])
    );
  end

  // --------------------------------------------------------------------------
  // Median pick per channel, then the output register.
  // --------------------------------------------------------------------------
  sample_t left_pick;
  sample_t right_pick;

  dcmm_select #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_left_select (
    .win    (left_win),
    .mags   (left_mags),
    .median (left_pick)
  );

  dcmm_select #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_right_select (
    .win    (right_win),
    .mags   (right_mags),
    .median (right_pick)
  );

  always_ff @(posedge clk) begin
    if (move) begin
      left_median  <= left_pick;
      right_median <= right_pick;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    count_stall |-> (s1_valid && median_valid && median_stall))
    else $error("input stalled while pipeline has room");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word did not reach window stage");

  a_s1_drains: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !median_valid) |=> median_valid)
    else $error("window stage did not drain into free output register");

  a_head_loaded: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((left_win[WINDOW_LEN-1] == $past(left_count)) &&
                (right_win[WINDOW_LEN-1] == $past(right_count))))
    else $error("newest tap does not hold accepted count");

endmodule

/* sv/dcmm_cell.sv */
// ----------------------------------------------------------------------------
// dcmm_cell: one tap of the sample window
// Holds a sample and its magnitude; loads from its neighbor on each shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcmm_cell
  import dcmm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    shift,
  input  sample_t din_sample,
  input  mag_t    din_mag,
  output sample_t sample,
  output mag_t    mag
);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
      mag    <= '0;
    end else if (shift) begin
      sample <= din_sample;
      mag    <= din_mag;
    end
  end

endmodule

/* sv/dcmm_select.sv */
// ----------------------------------------------------------------------------
// dcmm_select: stable magnitude rank and median pick over one window
// Every tap counts the taps ordered ahead of it; the tap at the middle rank
// drives the result. Ties go to the older tap (lower index).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcmm_select
  import dcmm_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input  sample_t win  [WINDOW_LEN],
  input  mag_t    mags [WINDOW_LEN],
  output sample_t median
);

  localparam int RANK_W = $clog2(WINDOW_LEN);
  localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW_LEN / 2);

  logic [RANK_W-1:0] rank [WINDOW_LEN];

  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if ((mags[j] < mags[i]) || ((mags[j] == mags[i]) && (j < i))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // ranks form a permutation, so exactly one tap hits the middle
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (rank[i] == MID_RANK) begin
        median = median | win[i];
      end
    end
  end

endmodule
